/* src/fhan_pkg.sv */
// Shared widths, constants and the side-band record for the fhan control pipeline.
package fhan_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int IN_W  = 32;   // error_pos, error_rate
    localparam int OUT_W = 30;   // control_out
    localparam int Y_W   = 42;   // 500*x1 + x2, signed
    localparam int AY_W  = 41;   // |Y|
    localparam int V_W   = 47;   // 100*one + 80*|Y| (without the FRAC_BITS scale of the radicand)
    localparam int A_W   = 44;   // intermediate a, signed

    localparam logic signed [63:0] OUT_MAX = 64'sd536870911;
    localparam logic signed [63:0] OUT_MIN = -64'sd536870912;

    // Data that rides alongside the square root stages.
    typedef struct packed {
        logic                    neg;      // y < 0
        logic                    big;      // |y| > d0
        logic signed [A_W-1:0]   a_small;  // x2 + Y
        logic signed [IN_W-1:0]  x2;
    } side_t;

endpackage

/* src/adrc_fhan_optimal_control_unit.sv */
// fhan time-optimal control, fully pipelined: one error pair per unstalled cycle.
//
// Input channel: error_pos / error_rate (signed Q(FRAC_BITS)) with in_valid / in_stall.
// Output channel: control_out (signed Q(FRAC_BITS), 30 bits) with out_valid / out_stall.
// A transaction completes on a rising clk edge with valid high and stall low.
//
// Every input transaction yields exactly one output transaction, in order.
// There are QW = (47 + FRAC_BITS + 1) / 2 square root stages. Throughput is one
// transaction per cycle while out_stall is low; the bit-serial restoring square
// root, one root bit per stage, sets the depth.
// Each stage holds its own valid bit and stage ready is !valid || downstream ready,
// so empty slots collapse while out_stall is high and a new transaction is taken
// whenever any slot up the pipe is free. The waiting result sits in the output
// register unchanged until taken.
//
// rst_n (asynchronous, active low) clears every valid bit; the pipe is empty after
// reset and in_stall is low.
module adrc_fhan_optimal_control_unit #(
    parameter int FRAC_BITS = fhan_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [fhan_pkg::IN_W-1:0]     error_pos,
    input  logic signed [fhan_pkg::IN_W-1:0]     error_rate,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [fhan_pkg::OUT_W-1:0]    control_out
);

    localparam int Y_W   = fhan_pkg::Y_W;
    localparam int AY_W  = fhan_pkg::AY_W;
    localparam int V_W   = fhan_pkg::V_W;
    localparam int A_W   = fhan_pkg::A_W;
    localparam int RAD_W = V_W + FRAC_BITS;
    localparam int QW    = (RAD_W + 1) / 2;
    localparam int PW    = FRAC_BITS + 15;   // -500*a with |a| <= 10
    localparam int RW    = FRAC_BITS + 16;   // selected result before clamping

    localparam int S_Y   = 0;
    localparam int S_ABS = 1;
    localparam int S_V   = 2;
    localparam int S_Q0  = 3;
    localparam int S_A   = S_Q0 + QW;
    localparam int S_B   = S_A + 1;
    localparam int S_C   = S_B + 1;
    localparam int NST   = S_C + 1;

    localparam logic signed [A_W-1:0] TEN     = A_W'(10) << FRAC_BITS;
    localparam logic signed [QW:0]    TEN_Q   = (QW + 1)'(10) << FRAC_BITS;
    localparam logic [V_W-1:0]        V_BASE  = V_W'(100) << FRAC_BITS;
    localparam logic signed [RW-1:0]  SAT_POS = RW'(5000) << FRAC_BITS;
    localparam logic signed [RW-1:0]  SAT_NEG = -SAT_POS;

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] rdy;
    logic [NST-1:0] ld;

    // ---------------- handshake chain ----------------
    assign rdy[NST-1] = !valid_reg[NST-1] || !out_stall;
    assign ld[0]      = rdy[0] && in_valid;

    genvar k;
    generate
        for (k = 0; k < NST - 1; k++) begin : g_rdy
            assign rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        for (k = 1; k < NST; k++) begin : g_ld
            assign ld[k] = rdy[k] && valid_reg[k-1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else begin
            if (rdy[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (rdy[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = valid_reg[NST-1];

    // ---------------- stage Y: Y = 500*x1 + x2 ----------------
    logic signed [Y_W-1:0]           y_reg, y_next;
    logic signed [fhan_pkg::IN_W-1:0] x2_y_reg;
    logic signed [Y_W-1:0]           x1_ext, x2_ext;

    always_comb
    begin
        x1_ext = Y_W'(error_pos);
        x2_ext = Y_W'(error_rate);
        // 500 = 512 - 8 - 4
        y_next = (x1_ext <<< 9) - (x1_ext <<< 3) - (x1_ext <<< 2) + x2_ext;
    end

    always_ff @(posedge clk)
    begin
        if (ld[S_Y]) begin
            y_reg    <= y_next;
            x2_y_reg <= error_rate;
        end
    end

    // ---------------- stage ABS: |Y|, branch flag, small-branch a ----------------
    logic [AY_W-1:0]   ay_reg, ay_next;
    fhan_pkg::side_t   side_abs_reg, side_abs_next;
    logic signed [Y_W-1:0] y_mag;

    always_comb
    begin
        y_mag                 = y_reg[Y_W-1] ? -y_reg : y_reg;
        ay_next               = y_mag[AY_W-1:0];
        side_abs_next.neg     = y_reg[Y_W-1];
        side_abs_next.big     = $signed({1'b0, y_mag}) > $signed({1'b0, TEN[A_W-2:0]});
        side_abs_next.a_small = A_W'(x2_y_reg) + A_W'(y_reg);
        side_abs_next.x2      = x2_y_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ld[S_ABS]) begin
            ay_reg       <= ay_next;
            side_abs_reg <= side_abs_next;
        end
    end

    // ---------------- stage V: 100*one + 80*|Y| ----------------
    logic [V_W-1:0]  v_reg, v_next;
    fhan_pkg::side_t side_v_reg;

    assign v_next = V_BASE + (V_W'(ay_reg) << 6) + (V_W'(ay_reg) << 4);

    always_ff @(posedge clk)
    begin
        if (ld[S_V]) begin
            v_reg      <= v_next;
            side_v_reg <= side_abs_reg;
        end
    end

    // ---------------- square root: one root bit per stage ----------------
    logic [QW+1:0]   rem_reg  [QW];
    logic [QW-1:0]   root_reg [QW];
    logic [2*QW-1:0] rad_reg  [QW];
    fhan_pkg::side_t side_q_reg [QW];

    genvar q;
    generate
        for (q = 0; q < QW; q++) begin : g_sqrt
            logic [QW+1:0]   rem_in;
            logic [QW-1:0]   root_in;
            logic [2*QW-1:0] rad_in;
            fhan_pkg::side_t side_in;
            logic [QW+1:0]   rem_sh;
            logic [QW+1:0]   trial;
            logic            ge;

            if (q == 0) begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign rad_in  = (2 * QW)'({v_reg, {FRAC_BITS{1'b0}}});
                assign side_in = side_v_reg;
            end
            else begin : g_next
                assign rem_in  = rem_reg[q-1];
                assign root_in = root_reg[q-1];
                assign rad_in  = rad_reg[q-1];
                assign side_in = side_q_reg[q-1];
            end

            assign rem_sh = {rem_in[QW-1:0], rad_in[2*QW-1 -: 2]};
            assign trial  = {root_in, 2'b01};
            assign ge     = rem_sh >= trial;

            always_ff @(posedge clk)
            begin
                if (ld[S_Q0 + q]) begin
                    rem_reg[q]    <= ge ? rem_sh - trial : rem_sh;
                    root_reg[q]   <= {root_in[QW-2:0], ge};
                    rad_reg[q]    <= rad_in << 2;
                    side_q_reg[q] <= side_in;
                end
            end
        end
    endgenerate

    // ---------------- stage A: form a ----------------
    logic signed [A_W-1:0] a_reg, a_next;
    logic signed [QW:0]    diff;
    logic [QW-1:0]         half;
    logic signed [A_W-1:0] half_ext, x2_ext_a;
    fhan_pkg::side_t       side_last;

    always_comb
    begin
        side_last = side_q_reg[QW-1];
        diff      = $signed({1'b0, root_reg[QW-1]}) - TEN_Q;
        half      = diff[QW] ? '0 : diff[QW:1];
        half_ext  = $signed({{(A_W - QW){1'b0}}, half});
        x2_ext_a  = A_W'(side_last.x2);
        if (side_last.big) begin
            a_next = side_last.neg ? x2_ext_a - half_ext : x2_ext_a + half_ext;
        end
        else begin
            a_next = side_last.a_small;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[S_A]) begin
            a_reg <= a_next;
        end
    end

    // ---------------- stage B: saturation flags and -500*a ----------------
    logic                   gt_reg, lt_reg;
    logic signed [PW-1:0]   prod_reg, prod_next;
    logic signed [PW-1:0]   a_trim;

    always_comb
    begin
        // only used when |a| <= 10, which fits FRAC_BITS + 5 bits
        a_trim    = PW'($signed(a_reg[FRAC_BITS+4:0]));
        prod_next = (a_trim <<< 3) + (a_trim <<< 2) - (a_trim <<< 9);
    end

    always_ff @(posedge clk)
    begin
        if (ld[S_B]) begin
            gt_reg   <= a_reg > TEN;
            lt_reg   <= a_reg < -TEN;
            prod_reg <= prod_next;
        end
    end

    // ---------------- stage C: select and clamp to the output width ----------------
    logic signed [fhan_pkg::OUT_W-1:0] out_reg, out_next;
    logic signed [RW-1:0]              r_sel;
    logic signed [63:0]                r_wide;

    always_comb
    begin
        if (gt_reg) begin
            r_sel = SAT_NEG;
        end
        else if (lt_reg) begin
            r_sel = SAT_POS;
        end
        else begin
            r_sel = RW'(prod_reg);
        end
        r_wide = 64'(r_sel);
        if (r_wide > fhan_pkg::OUT_MAX) begin
            out_next = fhan_pkg::OUT_MAX[fhan_pkg::OUT_W-1:0];
        end
        else if (r_wide < fhan_pkg::OUT_MIN) begin
            out_next = fhan_pkg::OUT_MIN[fhan_pkg::OUT_W-1:0];
        end
        else begin
            out_next = r_wide[fhan_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[S_C]) begin
            out_reg <= out_next;
        end
    end

    assign control_out = out_reg;

endmodule
